// ===== sv/rhc_pkg.sv =====
// Shared types and constants for the RGB to HSV converter.
package rhc_pkg;

	localparam int CHAN_W     = 8;
	localparam int HUE_W      = 16;
	// 6 * 255 = 1530 fits in 11 bits
	localparam int DEN_W      = 11;
	localparam int HUE_STEP   = 2;
	localparam int DIV_STAGES = HUE_W / HUE_STEP;

	// Payload carried through the divider stages.
	typedef struct packed {
		logic [DEN_W-1:0]  den;
		logic [DEN_W-1:0]  hue_rem;
		logic [HUE_W-1:0]  hue_q;
		logic [CHAN_W-1:0] sat_div;
		logic [CHAN_W-1:0] sat_rem;
		logic [CHAN_W-1:0] sat_sh;
		logic [CHAN_W-1:0] bright;
		logic [CHAN_W-1:0] alpha;
	} rhc_div_t;

endpackage

// ===== sv/rhc_div_stage.sv =====
// One stage of the hue and saturation restoring dividers.
module rhc_div_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  rhc_pkg::rhc_div_t in_data,
	output logic             out_valid,
	output rhc_pkg::rhc_div_t out_data
);
	import rhc_pkg::*;

	rhc_div_t          nxt;
	logic              vld_s1;
	rhc_div_t          res_s1;
	logic [DEN_W:0]    hue_t;
	logic [CHAN_W:0]   sat_t;

	always_comb begin
		nxt = in_data;
		// two hue quotient bits per stage
		for (int i = 0; i < HUE_STEP; i++) begin
			hue_t = {nxt.hue_rem, 1'b0};
			if (hue_t >= {1'b0, nxt.den}) begin
				hue_t     = hue_t - {1'b0, nxt.den};
				nxt.hue_q = {nxt.hue_q[HUE_W-2:0], 1'b1};
			end else begin
				nxt.hue_q = {nxt.hue_q[HUE_W-2:0], 1'b0};
			end
			nxt.hue_rem = hue_t[DEN_W-1:0];
		end
		// one saturation quotient bit; dividend bits shift out as quotient bits shift in
		sat_t = {nxt.sat_rem, nxt.sat_sh[CHAN_W-1]};
		if (sat_t >= {1'b0, nxt.sat_div}) begin
			sat_t      = sat_t - {1'b0, nxt.sat_div};
			nxt.sat_sh = {nxt.sat_sh[CHAN_W-2:0], 1'b1};
		end else begin
			nxt.sat_sh = {nxt.sat_sh[CHAN_W-2:0], 1'b0};
		end
		nxt.sat_rem = sat_t[CHAN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		res_s1 <= nxt;
	end

	assign out_valid = vld_s1;
	assign out_data  = res_s1;

endmodule

// ===== sv/rgb_to_hsv_convert_core.sv =====
// RGB to HSV converter: top level with min/max front end and divider pipeline.
// Throughput: one transaction per clock; busy is held low, so start may stay high.
// Two front-end stages (max/min, then delta and dividends) feed eight divider
// stages that each produce two hue quotient bits and one saturation bit.
// Reset (arst_n low, asynchronous) clears every valid bit; payload is not reset.
// The receiver cannot stall: done marks each result for exactly one cycle.
module rgb_to_hsv_convert_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic [7:0]  alpha_in,
	output logic        done,
	output logic [15:0] hue,
	output logic [7:0]  saturation,
	output logic [7:0]  brightness,
	output logic [7:0]  alpha_out
);
	import rhc_pkg::*;

	// which channel holds the maximum (red wins ties, then green)
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sect_t;

	// ---------------- stage 1: maximum, minimum and hue sector -------------
	logic [CHAN_W-1:0] mx_c;
	logic [CHAN_W-1:0] mn_c;
	sect_t             sect_c;

	logic              vld_s1;
	logic [CHAN_W-1:0] red_s1;
	logic [CHAN_W-1:0] green_s1;
	logic [CHAN_W-1:0] blue_s1;
	logic [CHAN_W-1:0] alpha_s1;
	logic [CHAN_W-1:0] mx_s1;
	logic [CHAN_W-1:0] mn_s1;
	sect_t             sect_s1;

	always_comb begin
		mx_c = red;
		if (green > mx_c) mx_c = green;
		if (blue > mx_c)  mx_c = blue;
		mn_c = red;
		if (green < mn_c) mn_c = green;
		if (blue < mn_c)  mn_c = blue;
		if (mx_c == red) begin
			sect_c = SECT_RED;
		end else if (mx_c == green) begin
			sect_c = SECT_GREEN;
		end else begin
			sect_c = SECT_BLUE;
		end
	end

	// ---------------- stage 2: delta, divisors and dividends ---------------
	logic [CHAN_W-1:0] delta_c;
	logic              grey_c;
	logic [DEN_W-1:0]  den_c;
	logic [CHAN_W:0]   diff_c;      // signed channel difference
	logic [DEN_W-1:0]  base_c;      // sector offset: 0, 2d, 4d, or 6d for a wrapped red hue
	logic [DEN_W:0]    num_c;
	logic [HUE_W-1:0]  sat_num_c;   // 255 * delta
	rhc_div_t          div_c;

	logic              vld_s2;
	rhc_div_t          div_s2;

	always_comb begin
		delta_c   = mx_s1 - mn_s1;
		grey_c    = (delta_c == '0);
		den_c     = {1'b0, delta_c, 2'b00} + {2'b00, delta_c, 1'b0};
		sat_num_c = {delta_c, 8'h00} - {8'h00, delta_c};
		diff_c    = '0;
		base_c    = '0;
		unique case (sect_s1)
			SECT_RED: begin
				diff_c = {1'b0, green_s1} - {1'b0, blue_s1};
				// negative hue wraps by one full turn
				base_c = (green_s1 >= blue_s1) ? '0 : den_c;
			end
			SECT_GREEN: begin
				diff_c = {1'b0, blue_s1} - {1'b0, red_s1};
				base_c = {2'b00, delta_c, 1'b0};
			end
			SECT_BLUE: begin
				diff_c = {1'b0, red_s1} - {1'b0, green_s1};
				base_c = {1'b0, delta_c, 2'b00};
			end
			default: begin
				diff_c = '0;
				base_c = '0;
			end
		endcase
		num_c = {1'b0, base_c} + {{(DEN_W-CHAN_W){diff_c[CHAN_W]}}, diff_c};

		div_c.bright  = mx_s1;
		div_c.alpha   = alpha_s1;
		div_c.hue_q   = '0;
		if (grey_c) begin
			// grey or black: divide zero by one so both quotients come out zero
			div_c.den     = DEN_W'(1);
			div_c.hue_rem = '0;
			div_c.sat_div = CHAN_W'(1);
			div_c.sat_rem = '0;
			div_c.sat_sh  = '0;
		end else begin
			div_c.den     = den_c;
			div_c.hue_rem = num_c[DEN_W-1:0];
			div_c.sat_div = mx_s1;
			// 255*delta < 256*max, so the upper byte is already below the divisor
			div_c.sat_rem = sat_num_c[HUE_W-1:CHAN_W];
			div_c.sat_sh  = sat_num_c[CHAN_W-1:0];
		end
	end

	// ---------------- valid bits for the front end ------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	// payload advances every cycle; only the valid bits matter
	always_ff @(posedge clk) begin
		red_s1   <= red;
		green_s1 <= green;
		blue_s1  <= blue;
		alpha_s1 <= alpha_in;
		mx_s1    <= mx_c;
		mn_s1    <= mn_c;
		sect_s1  <= sect_c;
		div_s2   <= div_c;
	end

	// ---------------- divider pipeline -----------------------------------
	logic     div_v [DIV_STAGES+1];
	rhc_div_t div_d [DIV_STAGES+1];

	assign div_v[0] = vld_s2;
	assign div_d[0] = div_s2;

	for (genvar gi = 0; gi < DIV_STAGES; gi++) begin : g_div
		rhc_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_v[gi]),
			.in_data   (div_d[gi]),
			.out_valid (div_v[gi+1]),
			.out_data  (div_d[gi+1])
		);
	end

	// ---------------- outputs --------------------------------------------
	// no stall path anywhere, so a new transaction is always taken
	assign busy       = 1'b0;
	assign done       = div_v[DIV_STAGES];
	assign hue        = div_d[DIV_STAGES].hue_q;
	assign saturation = div_d[DIV_STAGES].sat_sh;
	assign brightness = div_d[DIV_STAGES].bright;
	assign alpha_out  = div_d[DIV_STAGES].alpha;

`ifndef SYNTH
	// every result traces back to an earlier accepted transaction
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 10))
		else $error("result without a matching transaction");

	// grey pixels give zero hue and saturation
	a_grey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(red, 10) == $past(green, 10) && $past(green, 10) == $past(blue, 10))
		|-> (hue == '0 && saturation == '0))
		else $error("grey pixel produced non-zero hue or saturation");

	// brightness is the largest channel and alpha rides along with its pixel
	a_bright_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (brightness >= $past(red, 10) && brightness >= $past(green, 10) &&
			brightness >= $past(blue, 10) && alpha_out == $past(alpha_in, 10)))
		else $error("brightness or alpha out of step with its pixel");
`endif

endmodule
